// ----- rtl/mtg_pkg.sv -----
// Shared types, constants and functions for the MT19937 generator.
// No dependencies; imported by every other file of the block.
package mtg_pkg;

    localparam int unsigned STATE_WORDS  = 624;
    localparam int unsigned TWIST_OFFSET = 397;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned CNT_W        = $clog2(STATE_WORDS);

    localparam logic [CNT_W-1:0]  LAST_CELL    = CNT_W'(STATE_WORDS - 1);

    localparam logic [WORD_W-1:0] MATRIX_A     = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd6069;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;

    // transaction kind carried in tuser
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_DRAW
    } t_state;

    // next word of the sequence from the head window
    function automatic logic [WORD_W-1:0] twist_word(
        input logic [WORD_W-1:0] head,
        input logic [WORD_W-1:0] nxt,
        input logic [WORD_W-1:0] far
    );
        logic [WORD_W-1:0] y;
        y = (head & HIGH_BIT) | (nxt & LOW_BITS);
        return far ^ (y >> 1) ^ (y[0] ? MATRIX_A : '0);
    endfunction

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ----- rtl/mersenne_twister_generator_top.sv -----
// MT19937 generator top level: cell chain, twist unit, control and output stage.
// Depends on mtg_pkg, mtg_cell and mtg_twist.
//
// 32-bit MT19937 generator. The 624-word state lives in a chain of 624
// cells that all shift one place towards cell 0 together; cell 0 holds the
// oldest word x[n]. On a draw (tuser = 0) the twist unit combines cells
// 0, 1 and 397 into x[n+624], which enters the tail of the chain while its
// tempered value goes to the output register or, if that stalls, the skid
// register, so draws can follow one another every cycle while input is
// ready. A reseed transaction (tuser = 1, seed in tdata) refills the chain
// one word per cycle through the 6069 multiplier at the tail, with no
// result and input not ready meanwhile. A draw before any seed first runs
// that fill with seed 4357, then draws. Results go through an output
// register backed by a one-entry skid register, so input is still taken
// while a result waits for m_axis_tready, until the skid register fills.
// State words are undefined after reset; nothing reads them before a fill.
module mersenne_twister_generator_top
    import mtg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [WORD_W-1:0] i_s_axis_tdata,   // [31:0] seed_value
    input  logic [0:0]        i_s_axis_tuser,   // [0] operation
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [WORD_W-1:0] o_m_axis_tdata    // [31:0] random_word
);

    t_state r_state, n_state;
    logic [CNT_W-1:0]  r_fill_cnt, n_fill_cnt;
    logic              r_seeded, n_seeded;
    logic              r_pend_draw, n_pend_draw;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_data, n_out_data;
    logic              r_skid_valid, n_skid_valid;
    logic [WORD_W-1:0] r_skid_data, n_skid_data;

    logic              w_accept;
    logic              w_shift;
    logic              w_push;
    logic [WORD_W-1:0] w_feed;
    logic [WORD_W-1:0] w_twisted;
    logic [WORD_W-1:0] w_tempered;
    logic [WORD_W-1:0] w_cell [STATE_WORDS];

    // ---------------- cell chain ----------------
    for (genvar g = 0; g < STATE_WORDS; g++) begin : g_chain
        if (g == STATE_WORDS - 1) begin : g_tail
            mtg_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_word (w_feed),
                .o_word (w_cell[g])
            );
        end else begin : g_body
            mtg_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_word (w_cell[g+1]),
                .o_word (w_cell[g])
            );
        end
    end

    mtg_twist u_twist (
        .i_head    (w_cell[0]),
        .i_next    (w_cell[1]),
        .i_far     (w_cell[TWIST_OFFSET]),
        .o_word    (w_twisted),
        .o_tempered(w_tempered)
    );

    // ---------------- control ----------------
    assign o_s_axis_tready = (r_state == ST_IDLE) && !r_skid_valid;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_fill_cnt  = r_fill_cnt;
        n_seeded    = r_seeded;
        n_pend_draw = r_pend_draw;
        w_shift     = 1'b0;
        w_push      = 1'b0;
        w_feed      = w_twisted;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_s_axis_tuser[0] == OP_RESEED) begin
                        // seed word enters the tail, rest follows by multiplication
                        w_shift     = 1'b1;
                        w_feed      = i_s_axis_tdata;
                        n_seeded    = 1'b1;
                        n_pend_draw = 1'b0;
                        n_fill_cnt  = CNT_W'(1);
                        n_state     = ST_FILL;
                    end else if (!r_seeded) begin
                        w_shift     = 1'b1;
                        w_feed      = DEFAULT_SEED;
                        n_seeded    = 1'b1;
                        n_pend_draw = 1'b1;
                        n_fill_cnt  = CNT_W'(1);
                        n_state     = ST_FILL;
                    end else begin
                        w_shift = 1'b1;
                        w_push  = 1'b1;
                    end
                end
            end
            ST_FILL: begin
                w_shift    = 1'b1;
                w_feed     = WORD_W'(w_cell[STATE_WORDS-1] * SEED_MULT);
                n_fill_cnt = r_fill_cnt + CNT_W'(1);
                if (r_fill_cnt == LAST_CELL) begin
                    n_state = r_pend_draw ? ST_DRAW : ST_IDLE;
                end
            end
            ST_DRAW: begin
                // deferred draw after the default seed fill
                w_shift     = 1'b1;
                w_push      = 1'b1;
                n_pend_draw = 1'b0;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------- output register and skid ----------------
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (!r_out_valid || i_m_axis_tready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = w_push;
                n_skid_data  = w_tempered;
            end else begin
                n_out_valid = w_push;
                n_out_data  = w_tempered;
            end
        end else if (w_push) begin
            n_skid_valid = 1'b1;
            n_skid_data  = w_tempered;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_fill_cnt   <= '0;
            r_seeded     <= 1'b0;
            r_pend_draw  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_fill_cnt   <= n_fill_cnt;
            r_seeded     <= n_seeded;
            r_pend_draw  <= n_pend_draw;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ---------------- assertions ----------------
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    a_no_push_over_skid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !r_skid_valid)
        else $error("result produced with the skid register already full");

    a_fill_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL && r_fill_cnt == LAST_CELL) |=> (r_state != ST_FILL))
        else $error("state fill ran past the last cell");

    a_draw_after_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAW) |-> ($past(r_state) == ST_FILL && r_pend_draw))
        else $error("deferred draw without a preceding default seed fill");

endmodule

// ----- rtl/mtg_cell.sv -----
// One state cell of the MT19937 shift chain: holds a single state word.
// Depends on mtg_pkg.
module mtg_cell
    import mtg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_shift,
    input  logic [WORD_W-1:0] i_word,   // from the neighbour further down the chain
    output logic [WORD_W-1:0] o_word
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        n_word = i_shift ? i_word : r_word;
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ----- rtl/mtg_twist.sv -----
// Twist and temper unit: forms the next sequence word from the chain taps
// and its tempered output value. Depends on mtg_pkg.
module mtg_twist
    import mtg_pkg::*;
(
    input  logic [WORD_W-1:0] i_head,   // x[n]
    input  logic [WORD_W-1:0] i_next,   // x[n+1]
    input  logic [WORD_W-1:0] i_far,    // x[n+397]
    output logic [WORD_W-1:0] o_word,   // x[n+624]
    output logic [WORD_W-1:0] o_tempered
);

    always_comb begin
        o_word     = twist_word(i_head, i_next, i_far);
        o_tempered = temper(o_word);
    end

endmodule
